/* hdl/sba_pkg.sv */
// Shared types, widths and codes of the slab block allocator.
package sba_pkg;

	localparam int MAX_BLOCKS   = 1024;
	localparam int HEADER_BYTES = 8;

	localparam int IDX_W    = 10;
	localparam int CNT_W    = 11;
	localparam int CAP_W    = 11;
	localparam int BUCKET_W = 12;
	localparam int OFF_W    = 22;
	localparam int STATUS_W = 3;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int PROD_W   = IDX_W + BUCKET_W + 1;

	localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(1024);
	localparam logic [BUCKET_W-1:0] BUCKET_RESET = BUCKET_W'(64);
	localparam logic [OFF_W-1:0]    OFF_MAX      = {OFF_W{1'b1}};

	// request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_BUCKET   = 1'b1;

	// response status codes
	localparam logic [STATUS_W-1:0] RS_GRANTED   = 3'd0;
	localparam logic [STATUS_W-1:0] RS_EXHAUSTED = 3'd1;
	localparam logic [STATUS_W-1:0] RS_FREED     = 3'd2;
	localparam logic [STATUS_W-1:0] RS_FREED_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] RS_REJECTED  = 3'd4;

	typedef struct packed {
		logic start;  // request accepted: decide, update counters, touch stack
		logic load;   // form the response into the output register
	} ctrl_cmd_t;

endpackage

/* hdl/sba_if.sv */
// Request and response channel interfaces of the slab block allocator.
interface sba_req_if;
	logic                      valid;
	logic                      ready;
	logic                      op;
	logic [sba_pkg::IDX_W-1:0] freed_index;

	modport source (output valid, output op, output freed_index, input ready);
	modport sink (input valid, input op, input freed_index, output ready);
endinterface

interface sba_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [sba_pkg::IDX_W-1:0]    block_index;
	logic [sba_pkg::OFF_W-1:0]    byte_offset;
	logic [sba_pkg::STATUS_W-1:0] status;

	modport source (output valid, output ok, output block_index, output byte_offset,
		output status, input ready);
	modport sink (input valid, input ok, input block_index, input byte_offset,
		input status, output ready);
endinterface

/* hdl/slab_block_allocator_core.sv */
// Top level of the slab block allocator: controller, datapath and APB register port.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+------------------------------------------
//  req     | in  | valid / ready   | op, freed_index
//  rsp     | out | valid / ready   | ok, block_index, byte_offset, status
//  apb     | in  | psel / penable  | paddr, pwdata, pwrite; prdata out
//
// In the accept cycle a request updates counters and reads or writes
// the free stack memory; the response (stack read data -> offset
// multiply) is then loaded into the output register once it can take it.
// A new request is taken while a response still waits; the block then
// holds the second response until the first is taken. No clearing pass
// is needed after reset: the stack count guards every read.
module slab_block_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	sba_req_if.sink                       req,
	sba_rsp_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sba_pkg::PADDR_W-1:0]   paddr,
	input  logic [sba_pkg::PDATA_W-1:0]   pwdata,
	output logic [sba_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	sba_pkg::ctrl_cmd_t cmd;
	logic               cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	sba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	sba_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (req.op),
		.freed_index (req.freed_index),
		.cfg_we      (cfg_we),
		.cfg_sel     (paddr[2]),
		.cfg_wdata   (pwdata),
		.cfg_rdata   (prdata),
		.ok          (rsp.ok),
		.block_index (rsp.block_index),
		.byte_offset (rsp.byte_offset),
		.status      (rsp.status)
	);

endmodule

/* hdl/sba_ctrl.sv */
// Sequencing controller: accepts a request, runs it, holds the response valid.
module sba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output sba_pkg::ctrl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.start = in_ready && in_valid;
		cmd.load  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// wait here until the output register can take the response
					if (cmd.load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/sba_dp.sv */
// Datapath: config registers, counters, free stack memory, offset multiplier.
module sba_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sba_pkg::ctrl_cmd_t               cmd,
	input  logic                             op,
	input  logic [sba_pkg::IDX_W-1:0]        freed_index,
	input  logic                             cfg_we,
	input  logic                             cfg_sel,
	input  logic [sba_pkg::PDATA_W-1:0]      cfg_wdata,
	output logic [sba_pkg::PDATA_W-1:0]      cfg_rdata,
	output logic                             ok,
	output logic [sba_pkg::IDX_W-1:0]        block_index,
	output logic [sba_pkg::OFF_W-1:0]        byte_offset,
	output logic [sba_pkg::STATUS_W-1:0]     status
);

	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_STACK,
		SEL_FRESH
	} idx_sel_t;

	logic [sba_pkg::CAP_W-1:0]    cap_q;
	logic [sba_pkg::BUCKET_W-1:0] bucket_q;
	logic [sba_pkg::CNT_W-1:0]    handed_q;
	logic [sba_pkg::CNT_W-1:0]    stk_cnt_q;

	logic [sba_pkg::IDX_W-1:0] stack_mem [sba_pkg::MAX_BLOCKS];
	logic [sba_pkg::IDX_W-1:0] rd_data_q;

	idx_sel_t                     sel_q;
	logic [sba_pkg::IDX_W-1:0]    fresh_idx_q;
	logic [sba_pkg::STATUS_W-1:0] res_status_q;
	logic                         res_ok_q;

	logic                         ok_q;
	logic [sba_pkg::IDX_W-1:0]    idx_q;
	logic [sba_pkg::OFF_W-1:0]    off_q;
	logic [sba_pkg::STATUS_W-1:0] status_q;

	logic [sba_pkg::CNT_W-1:0]    cap_eff;
	logic [sba_pkg::CNT_W-1:0]    stk_cnt_inc;
	logic [sba_pkg::CNT_W-1:0]    stk_cnt_dec;
	logic                         do_pop;
	logic                         do_fresh;
	logic                         do_push;
	logic [sba_pkg::IDX_W-1:0]    grant_idx;
	logic [sba_pkg::BUCKET_W:0]   stride;
	logic [sba_pkg::PROD_W-1:0]   prod;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= sba_pkg::CAP_RESET;
			bucket_q <= sba_pkg::BUCKET_RESET;
		end else if (cfg_we) begin
			case (cfg_sel)
				sba_pkg::REG_CAPACITY: cap_q    <= cfg_wdata[sba_pkg::CAP_W-1:0];
				sba_pkg::REG_BUCKET:   bucket_q <= cfg_wdata[sba_pkg::BUCKET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			sba_pkg::REG_CAPACITY: cfg_rdata = sba_pkg::PDATA_W'(cap_q);
			sba_pkg::REG_BUCKET:   cfg_rdata = sba_pkg::PDATA_W'(bucket_q);
			default:               cfg_rdata = '0;
		endcase
	end

	// request decision
	always_comb begin
		cap_eff = (cap_q > sba_pkg::CNT_W'(sba_pkg::MAX_BLOCKS)) ?
			sba_pkg::CNT_W'(sba_pkg::MAX_BLOCKS) : cap_q;
		stk_cnt_inc = stk_cnt_q + 1'b1;
		stk_cnt_dec = stk_cnt_q - 1'b1;
		do_pop   = (op == sba_pkg::OP_ALLOC) && (stk_cnt_q != '0);
		do_fresh = (op == sba_pkg::OP_ALLOC) && (stk_cnt_q == '0) && (handed_q < cap_eff);
		// push only while the stack holds fewer entries than blocks handed out
		do_push  = (op == sba_pkg::OP_FREE) && (stk_cnt_q < handed_q) &&
			(stk_cnt_q < sba_pkg::CNT_W'(sba_pkg::MAX_BLOCKS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handed_q  <= '0;
			stk_cnt_q <= '0;
		end else if (cmd.start) begin
			if (do_pop) begin
				stk_cnt_q <= stk_cnt_dec;
			end else if (do_push) begin
				stk_cnt_q <= stk_cnt_inc;
			end
			if (do_fresh) begin
				handed_q <= handed_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (do_pop) begin
				sel_q <= SEL_STACK;
			end else if (do_fresh) begin
				sel_q <= SEL_FRESH;
			end else begin
				sel_q <= SEL_NONE;
			end
			fresh_idx_q <= handed_q[sba_pkg::IDX_W-1:0];
			res_ok_q    <= do_pop || do_fresh || do_push;
			if (op == sba_pkg::OP_ALLOC) begin
				res_status_q <= (do_pop || do_fresh) ? sba_pkg::RS_GRANTED :
					sba_pkg::RS_EXHAUSTED;
			end else if (!do_push) begin
				res_status_q <= sba_pkg::RS_REJECTED;
			end else begin
				res_status_q <= (stk_cnt_inc == handed_q) ? sba_pkg::RS_FREED_FULL :
					sba_pkg::RS_FREED;
			end
		end
	end

	// free stack memory: at most one access per request, read data registered
	always_ff @(posedge clk) begin
		if (cmd.start && do_push) begin
			stack_mem[stk_cnt_q[sba_pkg::IDX_W-1:0]] <= freed_index;
		end
		if (cmd.start && do_pop) begin
			rd_data_q <= stack_mem[stk_cnt_dec[sba_pkg::IDX_W-1:0]];
		end
	end

	// response formation
	always_comb begin
		case (sel_q)
			SEL_STACK: grant_idx = rd_data_q;
			SEL_FRESH: grant_idx = fresh_idx_q;
			default:   grant_idx = '0;
		endcase
		stride = (sba_pkg::BUCKET_W+1)'(bucket_q) + (sba_pkg::BUCKET_W+1)'(sba_pkg::HEADER_BYTES);
		prod   = sba_pkg::PROD_W'(grant_idx) * sba_pkg::PROD_W'(stride);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok_q     <= res_ok_q;
			idx_q    <= grant_idx;
			off_q    <= (prod > sba_pkg::PROD_W'(sba_pkg::OFF_MAX)) ? sba_pkg::OFF_MAX :
				prod[sba_pkg::OFF_W-1:0];
			status_q <= res_status_q;
		end
	end

	assign ok          = ok_q;
	assign block_index = idx_q;
	assign byte_offset = off_q;
	assign status      = status_q;

endmodule

/* hdl/sba_chk.sv */
// Port-level checker for the slab block allocator, bound to the top level.
module sba_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_ok,
	input logic [sba_pkg::IDX_W-1:0]     rsp_block_index,
	input logic [sba_pkg::OFF_W-1:0]     rsp_byte_offset,
	input logic [sba_pkg::STATUS_W-1:0]  rsp_status
);

	// a stalled response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// ok agrees with the status code
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_ok == ((rsp_status == sba_pkg::RS_GRANTED) ||
			(rsp_status == sba_pkg::RS_FREED) || (rsp_status == sba_pkg::RS_FREED_FULL))))
		else $error("ok does not match status");

	// only a grant carries an index and offset
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != sba_pkg::RS_GRANTED) |->
			(rsp_block_index == '0) && (rsp_byte_offset == '0))
		else $error("index or offset set without a grant");

	// index zero always maps to offset zero
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_block_index == '0) |-> (rsp_byte_offset == '0))
		else $error("nonzero offset for block zero");

endmodule

bind slab_block_allocator_core sba_chk u_sba_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_ok          (rsp.ok),
	.rsp_block_index (rsp.block_index),
	.rsp_byte_offset (rsp.byte_offset),
	.rsp_status      (rsp.status)
);

/* bench/testbench.sv */
// Self-checking bench for the slab block allocator: random requests, stalls and register sweeps.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic                         ok;
		logic [sba_pkg::IDX_W-1:0]    block_index;
		logic [sba_pkg::OFF_W-1:0]    byte_offset;
		logic [sba_pkg::STATUS_W-1:0] status;
	} alloc_rsp_t;

	typedef struct {
		logic                      op;
		logic [sba_pkg::IDX_W-1:0] freed_index;
		int                        gap;
		bit                        drain;  // hold off until every response is back
	} alloc_req_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [sba_pkg::PADDR_W-1:0] paddr;
	logic [sba_pkg::PDATA_W-1:0] pwdata;
	logic [sba_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	sba_req_if req_ch ();
	sba_rsp_if rsp_ch ();

	slab_block_allocator_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// allocator shadow: registers, counters and free stack
	logic [sba_pkg::CAP_W-1:0]    capacity_reg;
	logic [sba_pkg::BUCKET_W-1:0] bucket_reg;
	int                           handed_out;
	int                           stack_depth;
	logic [sba_pkg::IDX_W-1:0]    stack_entry [sba_pkg::MAX_BLOCKS];

	alloc_req_t request_q[$];
	alloc_rsp_t expected_rsp_q[$];
	alloc_req_t cur_req;
	bit         cur_loaded;
	bit         offering;
	int         gap_left;
	int         n_accepted;
	int         n_checked;
	int         n_taken;
	int         error_count;
	int         cycle_count;

	always #2 clk = ~clk;

	function automatic logic [sba_pkg::OFF_W-1:0] offset_for(
			input logic [sba_pkg::IDX_W-1:0] idx);
		longint prod;
		prod = longint'(idx) * (longint'(sba_pkg::HEADER_BYTES) + longint'(bucket_reg));
		return (prod > longint'(sba_pkg::OFF_MAX)) ? sba_pkg::OFF_MAX :
			sba_pkg::OFF_W'(prod);
	endfunction

	function automatic alloc_rsp_t predict_response(input logic op,
			input logic [sba_pkg::IDX_W-1:0] fidx);
		alloc_rsp_t r;
		int eff_cap;
		logic [sba_pkg::IDX_W-1:0] g;
		r = '0;
		eff_cap = (int'(capacity_reg) > sba_pkg::MAX_BLOCKS) ? sba_pkg::MAX_BLOCKS :
			int'(capacity_reg);
		if (op == sba_pkg::OP_ALLOC) begin
			if (stack_depth > 0) begin
				stack_depth--;
				g = stack_entry[stack_depth];
				r.ok = 1'b1;
				r.block_index = g;
				r.byte_offset = offset_for(g);
				r.status = sba_pkg::RS_GRANTED;
			end else if (handed_out < eff_cap) begin
				g = sba_pkg::IDX_W'(handed_out);
				handed_out++;
				r.ok = 1'b1;
				r.block_index = g;
				r.byte_offset = offset_for(g);
				r.status = sba_pkg::RS_GRANTED;
			end else begin
				r.status = sba_pkg::RS_EXHAUSTED;
			end
		end else begin
			if (stack_depth >= handed_out || stack_depth >= sba_pkg::MAX_BLOCKS) begin
				r.status = sba_pkg::RS_REJECTED;
			end else begin
				stack_entry[stack_depth] = fidx;
				stack_depth++;
				r.ok = 1'b1;
				r.status = (stack_depth == handed_out) ? sba_pkg::RS_FREED_FULL :
					sba_pkg::RS_FREED;
			end
		end
		return r;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (offering && req_ch.ready) begin
				expected_rsp_q.push_back(predict_response(cur_req.op, cur_req.freed_index));
				n_accepted++;
				offering = 1'b0;
				cur_loaded = 1'b0;
			end
			if (!cur_loaded && request_q.size() > 0 &&
					!(request_q[0].drain && n_checked != n_accepted)) begin
				cur_req = request_q.pop_front();
				cur_loaded = 1'b1;
				gap_left = cur_req.gap;
			end
			if (cur_loaded && !offering) begin
				if (gap_left > 0)
					gap_left--;
				else
					offering = 1'b1;
			end
			if (offering) begin
				req_ch.valid <= 1'b1;
				req_ch.op <= cur_req.op;
				req_ch.freed_index <= cur_req.freed_index;
			end else begin
				req_ch.valid <= 1'b0;
				req_ch.op <= 1'($urandom);
				req_ch.freed_index <= sba_pkg::IDX_W'($urandom);
			end
		end
	end

	// response ready: random stalls, idle-free stretches, two long hold-offs
	int  stall_left;
	int  hold_left;
	bit  stall_mode;
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_taken++;
				if (n_taken % 50 == 0)
					stall_mode = 1'($urandom);
				if (n_taken == 150 || n_taken == 520)
					hold_left = 100;
				else
					stall_left = stall_mode ? $urandom_range(0, 15) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		alloc_rsp_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: response with none expected: ok %0d index %0d offset %0d status %0d",
					$time, rsp_ch.ok, rsp_ch.block_index, rsp_ch.byte_offset, rsp_ch.status);
				error_count++;
			end else begin
				e = expected_rsp_q.pop_front();
				n_checked++;
				if (rsp_ch.ok !== e.ok) begin
					$display("%0t: ok expected %0d actual %0d", $time, e.ok, rsp_ch.ok);
					error_count++;
				end
				if (rsp_ch.block_index !== e.block_index) begin
					$display("%0t: block_index expected %0d actual %0d", $time,
						e.block_index, rsp_ch.block_index);
					error_count++;
				end
				if (rsp_ch.byte_offset !== e.byte_offset) begin
					$display("%0t: byte_offset expected %0d actual %0d", $time,
						e.byte_offset, rsp_ch.byte_offset);
					error_count++;
				end
				if (rsp_ch.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						e.status, rsp_ch.status);
					error_count++;
				end
			end
		end
	end

	task automatic reg_read_check(input logic reg_sel,
			input logic [sba_pkg::PDATA_W-1:0] value);
		logic [sba_pkg::PDATA_W-1:0] mask;
		mask = (reg_sel == sba_pkg::REG_CAPACITY) ?
			sba_pkg::PDATA_W'({sba_pkg::CAP_W{1'b1}}) :
			sba_pkg::PDATA_W'({sba_pkg::BUCKET_W{1'b1}});
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (value & mask)) begin
			$display("%0t: register %0d read expected %0d actual %0d", $time, reg_sel,
				value & mask, prdata & mask);
			error_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_write(input logic reg_sel, input logic [sba_pkg::PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == sba_pkg::REG_CAPACITY)
			capacity_reg = value[sba_pkg::CAP_W-1:0];
		else
			bucket_reg = value[sba_pkg::BUCKET_W-1:0];
		reg_read_check(reg_sel, value);
	endtask

	task automatic queue_request(input logic op, input logic [sba_pkg::IDX_W-1:0] idx,
			input int gap, input bit drain);
		alloc_req_t r;
		r.op = op;
		r.freed_index = idx;
		r.gap = gap;
		r.drain = drain;
		request_q.push_back(r);
	endtask

	// let everything drain, then let the two-stage pipe settle
	task automatic wait_idle();
		while (request_q.size() != 0 || cur_loaded || n_checked != n_accepted)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random_phase(input int count, input int alloc_pct);
		int i;
		bit idle_mode;
		logic op;
		logic [sba_pkg::IDX_W-1:0] idx;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 0)
				idle_mode = 1'($urandom);
			op = ($urandom_range(0, 99) < alloc_pct) ? sba_pkg::OP_ALLOC : sba_pkg::OP_FREE;
			if ($urandom_range(0, 9) == 0)
				idx = $urandom_range(0, 1) ? '0 : '1;
			else
				idx = sba_pkg::IDX_W'($urandom);
			queue_request(op, idx, idle_mode ? $urandom_range(0, 15) : 0, i == count / 2);
		end
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = sba_pkg::OP_ALLOC;
		req_ch.freed_index = '0;
		rsp_ch.ready = 1'b0;
		capacity_reg = sba_pkg::CAP_RESET;
		bucket_reg = sba_pkg::BUCKET_RESET;
		handed_out = 0;
		stack_depth = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		reg_read_check(sba_pkg::REG_CAPACITY, sba_pkg::PDATA_W'(sba_pkg::CAP_RESET));
		reg_read_check(sba_pkg::REG_BUCKET, sba_pkg::PDATA_W'(sba_pkg::BUCKET_RESET));

		// reset config: fresh grants, frees up to full, one rejected, LIFO pops
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '1, 0, 0);
		queue_request(sba_pkg::OP_FREE, 10'd1023, 0, 0);
		queue_request(sba_pkg::OP_FREE, 10'd0, 0, 0);
		queue_request(sba_pkg::OP_FREE, 10'h2AA, 0, 0);
		queue_request(sba_pkg::OP_FREE, 10'h155, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		wait_idle();

		// capacity below handed-out count, widest bucket: saturating offset
		reg_write(sba_pkg::REG_CAPACITY, 32'd2);
		reg_write(sba_pkg::REG_BUCKET, 32'd4095);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		queue_request(sba_pkg::OP_FREE, 10'd1023, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		wait_idle();

		// zero capacity still pops the stack
		reg_write(sba_pkg::REG_CAPACITY, 32'd0);
		reg_write(sba_pkg::REG_BUCKET, 32'd1);
		queue_request(sba_pkg::OP_FREE, 10'd5, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		wait_idle();

		// capacity above the arena size saturates
		reg_write(sba_pkg::REG_CAPACITY, 32'd2047);
		reg_write(sba_pkg::REG_BUCKET, 32'd2049);
		queue_request(sba_pkg::OP_ALLOC, '0, 0, 0);
		queue_request(sba_pkg::OP_FREE, 10'd0, 0, 0);
		queue_request(sba_pkg::OP_FREE, 10'd1, 0, 0);
		wait_idle();

		reg_write(sba_pkg::REG_CAPACITY, 32'd40);
		reg_write(sba_pkg::REG_BUCKET, 32'd1);
		run_random_phase(150, 60);

		reg_write(sba_pkg::REG_CAPACITY, 32'd1024);
		reg_write(sba_pkg::REG_BUCKET, sba_pkg::PDATA_W'($urandom_range(1, 2049)));
		run_random_phase(200, 75);

		reg_write(sba_pkg::REG_CAPACITY, 32'd1);
		reg_write(sba_pkg::REG_BUCKET, 32'd2049);
		run_random_phase(100, 50);

		reg_write(sba_pkg::REG_CAPACITY, sba_pkg::PDATA_W'($urandom_range(1, 1024)));
		reg_write(sba_pkg::REG_BUCKET, sba_pkg::PDATA_W'($urandom_range(1, 4095)));
		run_random_phase(250, 55);

		repeat (16) @(posedge clk);
		if (expected_rsp_q.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule
